// File: design/aprs_frame_classifier_defines.svh
// Assertion macros shared by the APRS frame classifier RTL.
`ifndef APRS_FRAME_CLASSIFIER_DEFINES_SVH
`define APRS_FRAME_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("afc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("afc assertion failed");

`endif

// File: design/afc_pkg.sv
// Types, character codes and helper functions for the APRS frame classifier.
package afc_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 5;
    localparam logic [CountW-1:0] CountMax = 5'd31;

    // Field tags carried with every echoed character.
    typedef enum logic [2:0] {
        TAG_SOURCE    = 3'd0,
        TAG_DEST      = 3'd1,
        TAG_PATH      = 3'd2,
        TAG_SEPARATOR = 3'd3,
        TAG_TYPE_CHAR = 3'd4,
        TAG_BODY      = 3'd5
    } field_tag_t;

    // Frame types reported on the final character.
    typedef enum logic [2:0] {
        FT_UNKNOWN  = 3'd0,
        FT_POSITION = 3'd1,
        FT_NMEA     = 3'd2,
        FT_MESSAGE  = 3'd3,
        FT_STATUS   = 3'd4,
        FT_WEATHER  = 3'd5
    } frame_type_t;

    localparam logic [ByteW-1:0] ChColon     = 8'h3A;
    localparam logic [ByteW-1:0] ChComma     = 8'h2C;
    localparam logic [ByteW-1:0] ChGreater   = 8'h3E;
    localparam logic [ByteW-1:0] ChBang      = 8'h21;
    localparam logic [ByteW-1:0] ChEqual     = 8'h3D;
    localparam logic [ByteW-1:0] ChSlash     = 8'h2F;
    localparam logic [ByteW-1:0] ChAt        = 8'h40;
    localparam logic [ByteW-1:0] ChDollar    = 8'h24;
    localparam logic [ByteW-1:0] ChHash      = 8'h23;
    localparam logic [ByteW-1:0] ChStar      = 8'h2A;
    localparam logic [ByteW-1:0] ChUnder     = 8'h5F;
    localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
    localparam logic [ByteW-1:0] ChSpace     = 8'h20;
    localparam logic [ByteW-1:0] ChDash      = 8'h2D;

    // Body length thresholds, expressed as body counts (type char included).
    localparam logic [CountW-1:0] CntMinLen    = 5'd11; // at least ten after type char
    localparam logic [CountW-1:0] CntNmeaLen   = 5'd12; // more than ten after type char
    localparam logic [CountW-1:0] CntCompPlain = 5'd14; // thirteen from position char
    localparam logic [CountW-1:0] CntCompStamp = 5'd21; // same, after a timestamp

    function automatic logic is_compressed_char(input logic [ByteW-1:0] c);
        return (c == ChSlash) || (c == ChBackslash) ||
               (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h6A);
    endfunction

    function automatic logic is_addressee_char(input logic [ByteW-1:0] c);
        return (c == ChSpace) || (c == ChDash) ||
               (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
    endfunction

endpackage

// File: design/aprs_frame_classifier.sv
// Top level of the APRS frame classifier: per-character tagging and frame checks.
//
//  Channel | Dir | tdata (low bit up)                          | tuser       | tlast
//  s_      | in  | [7:0] byte_in                               | -           | last_byte
//  m_      | out | [7:0] byte_out, [8] frame_valid,            | [2:0] tag   | frame_end
//          |     | [11:9] frame_type, [15:12] zero             |             |
//
// Every accepted word produces one result word in the next cycle; a word can be
// accepted in every cycle. The frame state is updated at the accepting edge and
// the tag, validity and type are computed by a short compare/counter path that
// ends in the output register. That single output register is the only buffer:
// a new word is accepted whenever it is empty or its word is being taken, so a
// stalled consumer stalls the producer only while the register is full.
// Reset (aresetn low, synchronous) empties the output register and returns the
// frame state to the start of a frame; the final character of each frame does
// the same for the frame state.
module aprs_frame_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] byte_out, [8] frame_valid, [11:9] frame_type
    output logic [2:0]  m_tuser,   // [2:0] field_tag
    output logic        m_tlast    // frame_end
);

    // Frame state.
    logic                        in_body_reg, in_body_next;
    logic [1:0]                  tokens_reg, tokens_next;
    logic                        tok_nonempty_reg, tok_nonempty_next;
    logic                        empty_tok_reg, empty_tok_next;
    logic [afc_pkg::CountW-1:0]  body_cnt_reg, body_cnt_next;
    logic [afc_pkg::ByteW-1:0]   type_char_reg, type_char_next;
    logic [afc_pkg::ByteW-1:0]   pos_char_reg, pos_char_next;
    logic                        addr_ok_reg, addr_ok_next;
    logic                        colon9_reg, colon9_next;
    logic                        dbl_bang_reg, dbl_bang_next;

    // Output register.
    logic                        out_valid_reg;
    logic [afc_pkg::ByteW-1:0]   out_byte_reg;
    afc_pkg::field_tag_t         out_tag_reg;
    logic                        out_last_reg;
    afc_pkg::frame_type_t        out_type_reg;

    afc_pkg::field_tag_t         tag;
    afc_pkg::frame_type_t        ftype;
    logic                        accept;
    logic [afc_pkg::ByteW-1:0]   c;
    logic                        stamp;

    assign c        = s_tdata;
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // State update for the current character; the close of a header token marks
    // an empty token if it held no character and counts it, saturating at three.
    always_comb begin
        in_body_next      = in_body_reg;
        tokens_next       = tokens_reg;
        tok_nonempty_next = tok_nonempty_reg;
        empty_tok_next    = empty_tok_reg;
        body_cnt_next     = body_cnt_reg;
        type_char_next    = type_char_reg;
        pos_char_next     = pos_char_reg;
        addr_ok_next      = addr_ok_reg;
        colon9_next       = colon9_reg;
        dbl_bang_next     = dbl_bang_reg;
        tag               = afc_pkg::TAG_BODY;

        if (!in_body_reg) begin
            if (c == afc_pkg::ChColon || c == afc_pkg::ChComma ||
                    c == afc_pkg::ChGreater) begin
                if (!tok_nonempty_reg) begin
                    empty_tok_next = 1'b1;
                end
                if (tokens_reg != 2'd3) begin
                    tokens_next = tokens_reg + 2'd1;
                end
                tok_nonempty_next = 1'b0;
                in_body_next      = (c == afc_pkg::ChColon);
                tag               = afc_pkg::TAG_SEPARATOR;
            end else begin
                tok_nonempty_next = 1'b1;
                case (tokens_reg)
                    2'd0:    tag = afc_pkg::TAG_SOURCE;
                    2'd1:    tag = afc_pkg::TAG_DEST;
                    default: tag = afc_pkg::TAG_PATH;
                endcase
            end
        end else if (body_cnt_reg == '0) begin
            type_char_next = c;
            body_cnt_next  = 5'd1;
            tag            = afc_pkg::TAG_TYPE_CHAR;
        end else begin
            // body_cnt_reg - 1 is the index of c after the type char.
            if (type_char_reg == afc_pkg::ChBang && body_cnt_reg == 5'd1 &&
                    c == afc_pkg::ChBang) begin
                dbl_bang_next = 1'b1;
            end
            if ((type_char_reg == afc_pkg::ChBang || type_char_reg == afc_pkg::ChEqual) &&
                    body_cnt_reg == 5'd1) begin
                pos_char_next = c;
            end
            if ((type_char_reg == afc_pkg::ChSlash || type_char_reg == afc_pkg::ChAt) &&
                    body_cnt_reg == 5'd8) begin
                pos_char_next = c;
            end
            if (body_cnt_reg < 5'd10 && !afc_pkg::is_addressee_char(c)) begin
                addr_ok_next = 1'b0;
            end
            if (body_cnt_reg == 5'd10 && c == afc_pkg::ChColon) begin
                colon9_next = 1'b1;
            end
            if (body_cnt_reg != afc_pkg::CountMax) begin
                body_cnt_next = body_cnt_reg + 5'd1;
            end
        end
    end

    // Classification on the state as it stands after this character.
    assign stamp = (type_char_next == afc_pkg::ChSlash) || (type_char_next == afc_pkg::ChAt);

    always_comb begin
        ftype = afc_pkg::FT_UNKNOWN;
        if (s_tlast && in_body_next && tokens_next >= 2'd2 && !empty_tok_next &&
                body_cnt_next >= 5'd2) begin
            case (type_char_next) inside
                afc_pkg::ChBang, afc_pkg::ChEqual, afc_pkg::ChSlash, afc_pkg::ChAt: begin
                    if (!(type_char_next == afc_pkg::ChBang && dbl_bang_next) &&
                            body_cnt_next >= afc_pkg::CntMinLen &&
                            !(afc_pkg::is_compressed_char(pos_char_next) &&
                              body_cnt_next >= (stamp ? afc_pkg::CntCompStamp
                                                      : afc_pkg::CntCompPlain))) begin
                        ftype = afc_pkg::FT_POSITION;
                    end
                end
                afc_pkg::ChDollar: begin
                    if (body_cnt_next >= afc_pkg::CntNmeaLen) begin
                        ftype = afc_pkg::FT_NMEA;
                    end
                end
                afc_pkg::ChColon: begin
                    if (body_cnt_next >= afc_pkg::CntMinLen && colon9_next && addr_ok_next) begin
                        ftype = afc_pkg::FT_MESSAGE;
                    end
                end
                afc_pkg::ChGreater: ftype = afc_pkg::FT_STATUS;
                afc_pkg::ChHash, afc_pkg::ChStar, afc_pkg::ChUnder: ftype = afc_pkg::FT_WEATHER;
                default: ftype = afc_pkg::FT_UNKNOWN;
            endcase
        end
    end

    // Frame state: back to the start of a frame after the final character.
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            in_body_reg      <= 1'b0;
            tokens_reg       <= 2'd0;
            tok_nonempty_reg <= 1'b0;
            empty_tok_reg    <= 1'b0;
            body_cnt_reg     <= '0;
            type_char_reg    <= '0;
            pos_char_reg     <= '0;
            addr_ok_reg      <= 1'b1;
            colon9_reg       <= 1'b0;
            dbl_bang_reg     <= 1'b0;
        end else if (accept) begin
            in_body_reg      <= in_body_next;
            tokens_reg       <= tokens_next;
            tok_nonempty_reg <= tok_nonempty_next;
            empty_tok_reg    <= empty_tok_next;
            body_cnt_reg     <= body_cnt_next;
            type_char_reg    <= type_char_next;
            pos_char_reg     <= pos_char_next;
            addr_ok_reg      <= addr_ok_next;
            colon9_reg       <= colon9_next;
            dbl_bang_reg     <= dbl_bang_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload of the output register needs no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_byte_reg <= c;
            out_tag_reg  <= tag;
            out_last_reg <= s_tlast;
            out_type_reg <= ftype;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_type_reg, (out_type_reg != afc_pkg::FT_UNKNOWN),
                       out_byte_reg};
    assign m_tuser  = out_tag_reg;
    assign m_tlast  = out_last_reg;

`include "aprs_frame_classifier_defines.svh"

    // A frame is only reported valid, with a known type, on its final word.
    `AFC_ASSERT_NOW(a_valid_only_at_end, aclk, aresetn, m_tvalid && (m_tdata[11:9] != 3'd0), m_tlast && m_tdata[8])

    // The final character of a frame leaves the state at the start of a frame.
    `AFC_ASSERT_NEXT(a_state_cleared, aclk, aresetn, accept && s_tlast, !in_body_reg && (body_cnt_reg == 5'd0) && (tokens_reg == 2'd0))

    // A taken result with no new word behind it empties the output register.
    `AFC_ASSERT_NEXT(a_drain, aclk, aresetn, m_tvalid && m_tready && !accept, !m_tvalid)

    // A body word after the type character keeps the frame in its body unless it was the final word.
    `AFC_ASSERT_NEXT(a_type_char_once, aclk, aresetn, accept && in_body_reg && (body_cnt_reg != 5'd0), in_body_reg || $past(s_tlast))

endmodule
